// ===== design/twsq_pkg.sv =====
`timescale 1ns / 1ps

package twsq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int FUNC_W    = 2;
   localparam int TASK_W    = 8;
   localparam int LIMIT_W   = 16;
   localparam int STATUS_W  = 3;
   localparam int WAITERS_W = 5;

   localparam logic [FUNC_W-1:0] FUNC_BLOCK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SIGNAL = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_SIGNALED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUED   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;

   typedef enum logic [2:0] {
      OP_HOLD = 3'd0,
      OP_PUSH = 3'd1,
      OP_POP  = 3'd2,
      OP_TICK = 3'd3,
      OP_DROP = 3'd4
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [TASK_W-1:0]  task_id;
      logic [LIMIT_W-1:0] limit;
      logic [CNT_W-1:0]   count;
   } cmd_type;

   typedef struct packed {
      logic [TASK_W-1:0]  task_id;
      logic [LIMIT_W-1:0] ticks;
      logic               unlimited;
      logic               expired;
   } cell_data_type;

   typedef struct packed {
      logic              hole;
      logic              second;
      logic [TASK_W-1:0] id;
   } chain_type;

endpackage

// ===== design/twsq_cell.sv =====
`timescale 1ns / 1ps

module twsq_cell
   import twsq_pkg::*;
(
   input  logic          clock,
   input  logic [IDX_W-1:0] idx,
   input  cmd_type       cmd,
   input  cell_data_type next_data,
   input  chain_type     chain_in,
   output cell_data_type data,
   output chain_type     chain_out
);

   cell_data_type data_ff;
   cell_data_type data_in;
   logic          in_range;
   logic          at_tail;
   logic          shift;

   assign in_range = CNT_W'(idx) < cmd.count;
   assign at_tail  = CNT_W'(idx) == cmd.count;
   assign shift    = chain_in.hole || data_ff.expired;

   always_comb begin
      data_in = data_ff;
      unique case (cmd.op)
         OP_HOLD: begin
         end
         OP_PUSH: begin
            if (at_tail) begin
               data_in.task_id   = cmd.task_id;
               data_in.ticks     = cmd.limit;
               data_in.unlimited = (cmd.limit == '0);
               data_in.expired   = 1'b0;
            end
         end
         OP_POP: begin
            data_in = next_data;
         end
         OP_TICK: begin
            data_in.expired = 1'b0;
            if (in_range && !data_ff.unlimited && data_ff.ticks != '0) begin
               data_in.ticks   = data_ff.ticks - 1'b1;
               data_in.expired = (data_ff.ticks == LIMIT_W'(1));
            end
         end
         OP_DROP: begin
            if (shift) begin
               data_in = next_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data             = data_ff;
   assign chain_out.hole   = chain_in.hole || data_ff.expired;
   assign chain_out.second = chain_in.second || (chain_in.hole && data_ff.expired);
   assign chain_out.id     = chain_in.id
                           | ((data_ff.expired && !chain_in.hole) ? data_ff.task_id : '0);

endmodule

// ===== design/timed_semaphore_wait_queue.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Payload
// req      in         req_valid/req_stall func, task_id, wait_limit
// rsp      out        rsp_valid/rsp_stall status, released_id, waiters, last
//
// Block, signal and unused codes each give one response.
// A tick first ages every cell, then gives one response per timed-out waiter
// (one response if none), so up to QUEUE_DEPTH responses; the row of cells is the limit.
// Reset clears the waiter count, the sequencer and the response valid; cells hold data only.
// A stalled response holds; requests wait while a response is stalled or a tick drains.

module timed_semaphore_wait_queue
   import twsq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [TASK_W-1:0]     req_task_id,
   input  logic [LIMIT_W-1:0]    req_wait_limit,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [TASK_W-1:0]     rsp_released_id,
   output logic [WAITERS_W-1:0]  rsp_waiters,
   output logic                  rsp_last
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [TASK_W-1:0]    id_ff, id_in;
   logic [CNT_W-1:0]     waiters_ff, waiters_in;
   logic                 last_ff, last_in;

   logic                 out_free;
   logic                 accept;
   cmd_type              cmd;
   cell_data_type        cell_data [QUEUE_DEPTH];
   chain_type            chain [QUEUE_DEPTH+1];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(state_ff == S_IDLE && out_free);
   assign accept    = req_valid && !req_stall;

   assign chain[0] = '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_data_type nxt;
      if (i == QUEUE_DEPTH - 1) begin : g_end
         assign nxt = '0;
      end else begin : g_mid
         assign nxt = cell_data[i+1];
      end
      twsq_cell u_cell (
         .clock     (clock),
         .idx       (IDX_W'(i)),
         .cmd       (cmd),
         .next_data (nxt),
         .chain_in  (chain[i]),
         .data      (cell_data[i]),
         .chain_out (chain[i+1])
      );
   end

   always_comb begin
      cmd.op      = OP_HOLD;
      cmd.task_id = req_task_id;
      cmd.limit   = req_wait_limit;
      cmd.count   = count_ff;
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      id_in        = id_ff;
      waiters_in   = waiters_ff;
      last_in      = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               last_in      = 1'b1;
               id_in        = '0;
               waiters_in   = count_ff;
               status_in    = ST_NONE;
               priority if (req_func == FUNC_BLOCK) begin
                  if (count_ff < CNT_W'(QUEUE_DEPTH)) begin
                     cmd.op     = OP_PUSH;
                     count_in   = count_ff + 1'b1;
                     status_in  = ST_QUEUED;
                     waiters_in = count_ff + 1'b1;
                  end else begin
                     status_in = ST_FULL;
                  end
               end else if (req_func == FUNC_SIGNAL) begin
                  if (count_ff != '0) begin
                     cmd.op     = OP_POP;
                     count_in   = count_ff - 1'b1;
                     status_in  = ST_SIGNALED;
                     id_in      = cell_data[0].task_id;
                     waiters_in = count_ff - 1'b1;
                  end
               end else if (req_func == FUNC_TICK) begin
                  cmd.op       = OP_TICK;
                  rsp_valid_in = 1'b0;
                  state_in     = S_SCAN;
               end else begin
               end
            end
         end
         S_SCAN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (chain[QUEUE_DEPTH].hole) begin
                  cmd.op     = OP_DROP;
                  count_in   = count_ff - 1'b1;
                  status_in  = ST_TIMEOUT;
                  id_in      = chain[QUEUE_DEPTH].id;
                  waiters_in = count_ff - 1'b1;
                  last_in    = !chain[QUEUE_DEPTH].second;
                  if (!chain[QUEUE_DEPTH].second) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  status_in  = ST_NONE;
                  id_in      = '0;
                  waiters_in = count_ff;
                  last_in    = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      status_ff  <= status_in;
      id_ff      <= id_in;
      waiters_ff <= waiters_in;
      last_ff    <= last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_released_id = id_ff;
   assign rsp_waiters     = WAITERS_W'(waiters_ff);
   assign rsp_last        = last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("waiter count above depth");

   a_scan_emits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && out_free) |=> rsp_valid_ff)
      else $error("scan cycle gave no response");

   a_drop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && out_free && chain[QUEUE_DEPTH].hole)
      |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("timeout release did not lower the count");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_BLOCK && count_ff < CNT_W'(QUEUE_DEPTH))
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("block did not raise the count");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last && !rsp_stall) |-> state_ff == S_IDLE)
      else $error("final response while tick still draining");
`endif

endmodule

// ===== test/twsq_release_checker.sv =====
`timescale 1ns / 1ps

module twsq_release_checker
   import twsq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [FUNC_W-1:0]     req_func,
   input  logic [TASK_W-1:0]     req_task_id,
   input  logic [LIMIT_W-1:0]    req_wait_limit,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic [TASK_W-1:0]     rsp_released_id,
   input  logic [WAITERS_W-1:0]  rsp_waiters,
   input  logic                  rsp_last,
   output int                    mismatches,
   output int                    outstanding
);

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [TASK_W-1:0]    id;
      logic [WAITERS_W-1:0] waiters;
      logic                 last;
   } release_type;

   logic [TASK_W-1:0]  waiting_task [QUEUE_DEPTH];
   logic [LIMIT_W-1:0] ticks_left [QUEUE_DEPTH];
   logic               unlimited [QUEUE_DEPTH];
   int                 waiting;
   release_type        expected_releases [$];

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatches++;
   endtask

   task automatic expect_release(input logic [STATUS_W-1:0] status,
                                 input logic [TASK_W-1:0] id,
                                 input int count, input logic fin);
      release_type r;
      r.status = status;
      r.id = id;
      r.waiters = WAITERS_W'(count);
      r.last = fin;
      expected_releases.push_back(r);
   endtask

   task automatic predict_request(input logic [FUNC_W-1:0] func,
                                  input logic [TASK_W-1:0] id,
                                  input logic [LIMIT_W-1:0] limit);
      int kept;
      int freed;
      bit expire;
      release_type r;
      case (func)
         FUNC_BLOCK: begin
            if (waiting >= QUEUE_DEPTH) begin
               expect_release(ST_FULL, '0, waiting, 1'b1);
            end else begin
               waiting_task[waiting] = id;
               ticks_left[waiting] = limit;
               unlimited[waiting] = (limit == '0);
               waiting++;
               expect_release(ST_QUEUED, '0, waiting, 1'b1);
            end
         end
         FUNC_SIGNAL: begin
            if (waiting == 0) begin
               expect_release(ST_NONE, '0, 0, 1'b1);
            end else begin
               expect_release(ST_SIGNALED, waiting_task[0], waiting - 1, 1'b1);
               for (int i = 1; i < waiting; i++) begin
                  waiting_task[i-1] = waiting_task[i];
                  ticks_left[i-1] = ticks_left[i];
                  unlimited[i-1] = unlimited[i];
               end
               waiting--;
            end
         end
         FUNC_TICK: begin
            kept = 0;
            freed = 0;
            for (int i = 0; i < waiting; i++) begin
               expire = 1'b0;
               if (!unlimited[i] && ticks_left[i] != '0) begin
                  ticks_left[i] = ticks_left[i] - 1'b1;
                  expire = (ticks_left[i] == '0);
               end
               if (expire) begin
                  expect_release(ST_TIMEOUT, waiting_task[i], waiting - freed - 1, 1'b0);
                  freed++;
               end else begin
                  waiting_task[kept] = waiting_task[i];
                  ticks_left[kept] = ticks_left[i];
                  unlimited[kept] = unlimited[i];
                  kept++;
               end
            end
            waiting = kept;
            if (freed == 0) begin
               expect_release(ST_NONE, '0, kept, 1'b1);
            end else begin
               r = expected_releases.pop_back();
               r.last = 1'b1;
               expected_releases.push_back(r);
            end
         end
         default: begin
            expect_release(ST_NONE, '0, waiting, 1'b1);
         end
      endcase
   endtask

   always @(posedge clock) begin : watch
      release_type want;
      if (reset) begin
         waiting = 0;
         expected_releases.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_request(req_func, req_task_id, req_wait_limit);
         if (rsp_valid && !rsp_stall) begin
            if (expected_releases.size() == 0) begin
               report_mismatch($sformatf("unexpected response status %0d id %0d waiters %0d",
                                         rsp_status, rsp_released_id, rsp_waiters));
            end else begin
               want = expected_releases.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, wanted %0d",
                                            rsp_status, want.status));
               if (rsp_released_id !== want.id)
                  report_mismatch($sformatf("released_id %0d, wanted %0d",
                                            rsp_released_id, want.id));
               if (rsp_waiters !== want.waiters)
                  report_mismatch($sformatf("waiters %0d, wanted %0d",
                                            rsp_waiters, want.waiters));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, wanted %0b", rsp_last, want.last));
            end
         end
      end
      outstanding <= expected_releases.size();
   end

endmodule

// ===== test/timed_semaphore_wait_queue_tb.sv =====
`timescale 1ns / 1ps

module timed_semaphore_wait_queue_tb;
   import twsq_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS  = 300;
   localparam int LONG_HOLD_CYCLES = 300;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [FUNC_W-1:0]    req_func = FUNC_BLOCK;
   logic [TASK_W-1:0]    req_task_id = '0;
   logic [LIMIT_W-1:0]   req_wait_limit = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [STATUS_W-1:0]  rsp_status;
   logic [TASK_W-1:0]    rsp_released_id;
   logic [WAITERS_W-1:0] rsp_waiters;
   logic                 rsp_last;
   int                   mismatches;
   int                   outstanding;
   bit                   idling = 1'b1;
   int                   hold_asks = 0;

   always #5 clock = ~clock;

   timed_semaphore_wait_queue dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_task_id     (req_task_id),
      .req_wait_limit  (req_wait_limit),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_released_id (rsp_released_id),
      .rsp_waiters     (rsp_waiters),
      .rsp_last        (rsp_last)
   );

   twsq_release_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_task_id     (req_task_id),
      .req_wait_limit  (req_wait_limit),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_released_id (rsp_released_id),
      .rsp_waiters     (rsp_waiters),
      .rsp_last        (rsp_last),
      .mismatches      (mismatches),
      .outstanding     (outstanding)
   );

   task automatic send_request(input logic [FUNC_W-1:0] func,
                               input logic [TASK_W-1:0] id,
                               input logic [LIMIT_W-1:0] limit);
      int gap;
      gap = 0;
      if (idling && $urandom_range(0, 3) == 0)
         gap = $urandom_range(1, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_task_id <= id;
      req_wait_limit <= limit;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain_releases();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [LIMIT_W-1:0] random_limit();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) return '0;
      if (pick < 70) return LIMIT_W'($urandom_range(1, 6));
      if (pick < 85) return LIMIT_W'($urandom_range(7, 40));
      return LIMIT_W'($urandom);
   endfunction

   task automatic send_random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45)
         send_request(FUNC_BLOCK, TASK_W'($urandom), random_limit());
      else if (pick < 65)
         send_request(FUNC_SIGNAL, TASK_W'($urandom), LIMIT_W'($urandom));
      else if (pick < 96)
         send_request(FUNC_TICK, TASK_W'($urandom), LIMIT_W'($urandom));
      else
         send_request(FUNC_UNUSED, TASK_W'($urandom), LIMIT_W'($urandom));
   endtask

   initial begin
      int served;
      served = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != served) begin
            served = hold_asks;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (idling && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      send_request(FUNC_SIGNAL, 8'h00, 16'h0000);
      send_request(FUNC_TICK, 8'hFF, 16'hFFFF);
      send_request(FUNC_UNUSED, 8'hFF, 16'hFFFF);
      send_request(FUNC_BLOCK, 8'h00, 16'h0000);
      send_request(FUNC_BLOCK, 8'hFF, 16'hFFFF);
      send_request(FUNC_BLOCK, 8'hA5, 16'h0001);
      send_request(FUNC_BLOCK, 8'h5A, 16'h0002);
      send_request(FUNC_TICK, 8'h00, 16'h0000);
      send_request(FUNC_TICK, 8'h00, 16'h0000);
      send_request(FUNC_SIGNAL, 8'hFF, 16'hFFFF);
      for (int i = 0; i < QUEUE_DEPTH; i++)
         send_request(FUNC_BLOCK, TASK_W'(8'h10 + i), 16'h0001);
      send_request(FUNC_TICK, 8'h00, 16'h0000);
      send_request(FUNC_SIGNAL, 8'h00, 16'h0000);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == 120) begin
            drain_releases();
            repeat (QUEUE_DEPTH)
               send_request(FUNC_SIGNAL, TASK_W'($urandom), LIMIT_W'($urandom));
            hold_asks <= hold_asks + 1;
            repeat (QUEUE_DEPTH + 4)
               send_request(FUNC_BLOCK, TASK_W'($urandom), 16'h0001);
            send_request(FUNC_TICK, TASK_W'($urandom), LIMIT_W'($urandom));
         end
         if (n == RANDOM_REQUESTS - 60)
            idling <= 1'b0;
         if (n % 90 == 45) begin
            repeat (QUEUE_DEPTH + 2)
               send_request(FUNC_BLOCK, TASK_W'($urandom), random_limit());
         end
         send_random_request();
      end

      drain_releases();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== timed_semaphore_wait_queue.f =====
design/twsq_pkg.sv
design/twsq_cell.sv
design/timed_semaphore_wait_queue.sv
test/twsq_release_checker.sv
test/timed_semaphore_wait_queue_tb.sv
